>>> rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter: sequencer states,
// register indexes, action codes, gain format and register reset values.
// ----------------------------------------------------------------------------
package skf_pkg;

	// Gain is Q1.16: GAIN_ONE stands for one, GAIN_W holds values up to one.
	localparam int unsigned GAIN_FRAC = 16;
	localparam int unsigned GAIN_W    = GAIN_FRAC + 1;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

	// Step counter covers the longest loop (GAIN_W multiply steps).
	localparam int unsigned CNT_W = 5;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(GAIN_FRAC - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_FRAC);

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = 2'd3;

	// Reset values, wide enough for any data width; users take the low bits.
	localparam logic [63:0] RST_PROCESS_NOISE      = 64'd655;
	localparam logic [63:0] RST_MEASUREMENT_NOISE  = 64'd65536;
	localparam logic [63:0] RST_INITIAL_COVARIANCE = 64'd65536;
	localparam logic [63:0] RST_INITIAL_ESTIMATE   = 64'd0;
	localparam logic [63:0] RST_COVARIANCE         = 64'd65536;

	// Input action codes.
	localparam logic ACT_UPDATE  = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_ADDQ = 11'b000_0000_0010,
		ST_ADDR = 11'b000_0000_0100,
		ST_DIV0 = 11'b000_0000_1000,
		ST_DIV  = 11'b000_0001_0000,
		ST_DIFF = 11'b000_0010_0000,
		ST_ABS  = 11'b000_0100_0000,
		ST_MULE = 11'b000_1000_0000,
		ST_EST  = 11'b001_0000_0000,
		ST_MULP = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} skf_state_t;

endpackage

>>> rtl/skf_addsub.sv
// ----------------------------------------------------------------------------
// skf_addsub
// Shared adder/subtractor of the filter. With sub high it forms a - b and
// carry is high when no borrow occurred (a >= b); otherwise carry is the
// carry out of a + b.
// ----------------------------------------------------------------------------
module skf_addsub #(
	parameter int unsigned W = 34
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);

	logic [W:0] full;

	assign full  = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
	assign sum   = full[W-1:0];
	assign carry = full[W];

endmodule

>>> rtl/scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// An update beat goes from acceptance to the result beat through 17 divide
// steps, two 17-step multiplies and six single steps; a restart beat goes
// straight to the final step. One beat is in work at a time, since every
// step uses the single shared adder, and the next beat is accepted only in
// the idle state; a result the receiver has not yet taken stalls the final
// step.
// Reset (arst_n low) clears the estimate to 0, the covariance to one and the
// configuration registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core
	import skf_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic [REG_IDX_W-1:0]                  cfg_index,
	input  logic [DATA_WIDTH-1:0]                 cfg_data,
	// Input beats.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// s_tdata: measurement, zero padding to whole bytes.
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
	// s_tuser: action (0 update, 1 restart).
	input  logic                                  s_tuser,
	// Result beats.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// m_tdata: estimate, gain, covariance, saturated, zero padding.
	output logic [((2*DATA_WIDTH+GAIN_W+1+7)/8)*8-1:0] m_tdata
);

	localparam int unsigned DW    = DATA_WIDTH;
	// The adder is two bits wider than the data: the difference of two
	// signed values and the shifted divide remainder both need them.
	localparam int unsigned AW    = DW + 2;
	localparam int unsigned OUT_W = ((2*DW+GAIN_W+1+7)/8)*8;

	localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	// Configuration registers.
	logic [DW-1:0] q_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] init_cov_q;
	logic [DW-1:0] init_est_q;

	// Filter state.
	logic [DW-1:0] est_q;
	logic [DW-1:0] cov_q;

	// Working registers of the sequencer.
	skf_state_t    state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0] meas_q;
	logic [DW-1:0] p1_q;
	logic [DW:0]   den_q;
	logic          den_zero_q;
	logic [DW:0]   rem_q;
	logic [GAIN_W-1:0] gain_q;
	logic [GAIN_W-1:0] mr_q;
	logic [AW-1:0] diff_q;
	logic          neg_q;
	logic [AW-1:0] acc_q;
	logic          sat_q;

	// Shared adder.
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	logic          alu_sub;
	logic [AW-1:0] alu_sum;
	logic          alu_carry;

	logic          in_beat;
	logic          out_free;
	logic          qbit;
	logic [AW-1:0] mul_x;
	logic          est_ovf;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// A quotient bit is set when the trial subtraction does not borrow; a
	// zero denominator forces the gain to zero.
	assign qbit = alu_carry && !den_zero_q;

	// The multiplicand is the innovation magnitude first, then the
	// predicted covariance.
	assign mul_x = (state_q == ST_MULE) ? diff_q : AW'(p1_q);

	// The corrected estimate fits when its top three bits agree.
	assign est_ovf = !((&alu_sum[AW-1:DW-1]) || (~|alu_sum[AW-1:DW-1]));

	skf_addsub #(
		.W(AW)
	) u_addsub (
		.a    (alu_a),
		.b    (alu_b),
		.sub  (alu_sub),
		.sum  (alu_sum),
		.carry(alu_carry)
	);

	// Operand selection for the shared adder in each step.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_ADDQ: begin
				// Predicted covariance p + q.
				alu_a = AW'(cov_q);
				alu_b = AW'(q_q);
			end
			ST_ADDR: begin
				// Divisor p1 + r.
				alu_a = AW'(p1_q);
				alu_b = AW'(r_q);
			end
			ST_DIV0: begin
				// Integer quotient bit: p1 never exceeds the divisor.
				alu_a   = AW'(p1_q);
				alu_b   = AW'(den_q);
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = {rem_q, 1'b0};
				alu_b   = AW'(den_q);
				alu_sub = 1'b1;
			end
			ST_DIFF: begin
				// Innovation: measurement minus estimate, both sign-extended.
				alu_a   = {{2{meas_q[DW-1]}}, meas_q};
				alu_b   = {{2{est_q[DW-1]}}, est_q};
				alu_sub = 1'b1;
			end
			ST_ABS: begin
				alu_b   = diff_q;
				alu_sub = 1'b1;
			end
			ST_MULE, ST_MULP: begin
				// Shift-add multiply, one multiplier bit per step.
				alu_a = acc_q;
				alu_b = mr_q[0] ? mul_x : '0;
			end
			ST_EST: begin
				// Move the estimate by the scaled innovation, toward its sign.
				alu_a   = {{2{est_q[DW-1]}}, est_q};
				alu_b   = acc_q;
				alu_sub = neg_q;
			end
			ST_IDLE, ST_DONE: begin
				alu_sub = 1'b0;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q        <= RST_PROCESS_NOISE[DW-1:0];
			r_q        <= RST_MEASUREMENT_NOISE[DW-1:0];
			init_cov_q <= RST_INITIAL_COVARIANCE[DW-1:0];
			init_est_q <= RST_INITIAL_ESTIMATE[DW-1:0];
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROCESS_NOISE:      q_q        <= cfg_data;
				REG_MEASUREMENT_NOISE:  r_q        <= cfg_data;
				REG_INITIAL_COVARIANCE: init_cov_q <= cfg_data;
				REG_INITIAL_ESTIMATE:   init_est_q <= cfg_data;
				default:                q_q        <= q_q;
			endcase
		end
	end

	// Sequencer and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			est_q    <= '0;
			cov_q    <= RST_COVARIANCE[DW-1:0];
			m_tvalid <= 1'b0;
		end else begin
			// In the final step the valid flag is set there instead.
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						sat_q  <= 1'b0;
						meas_q <= s_tdata[DW-1:0];
						if (s_tuser == ACT_RESTART) begin
							// Restart reloads the state and reports a zero gain.
							est_q   <= init_est_q;
							cov_q   <= init_cov_q;
							gain_q  <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ADDQ;
						end
					end
				end
				ST_ADDQ: begin
					// Clip the predicted covariance at the largest value.
					if (alu_sum[DW]) begin
						p1_q  <= '1;
						sat_q <= 1'b1;
					end else begin
						p1_q <= alu_sum[DW-1:0];
					end
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					den_q      <= alu_sum[DW:0];
					den_zero_q <= (alu_sum[DW:0] == '0);
					state_q    <= ST_DIV0;
				end
				ST_DIV0: begin
					gain_q  <= GAIN_W'(qbit);
					rem_q   <= qbit ? alu_sum[DW:0] : {1'b0, p1_q};
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// Restoring division, one fraction bit per cycle. The
					// remainder stays below the divisor, so it fits DW+1 bits.
					gain_q <= {gain_q[GAIN_W-2:0], qbit};
					rem_q  <= qbit ? alu_sum[DW:0] : alu_a[DW:0];
					cnt_q  <= cnt_q + CNT_W'(1);
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					diff_q  <= alu_sum;
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					neg_q <= diff_q[AW-1];
					if (diff_q[AW-1]) begin
						diff_q <= alu_sum;
					end
					acc_q   <= '0;
					mr_q    <= gain_q;
					cnt_q   <= '0;
					state_q <= ST_MULE;
				end
				ST_MULE, ST_MULP: begin
					// The low sixteen product bits are shifted out; the top
					// multiplier bit is added without a shift.
					if (cnt_q == MUL_LAST) begin
						acc_q <= alu_sum;
					end else begin
						acc_q <= {1'b0, alu_sum[AW-1:1]};
					end
					mr_q  <= {1'b0, mr_q[GAIN_W-1:1]};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == MUL_LAST) begin
						if (state_q == ST_MULE) begin
							state_q <= ST_EST;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_EST: begin
					if (est_ovf) begin
						est_q <= alu_sum[AW-1] ? SMIN : SMAX;
						sat_q <= 1'b1;
					end else begin
						est_q <= alu_sum[DW-1:0];
					end
					acc_q   <= '0;
					mr_q    <= GAIN_ONE - gain_q;
					cnt_q   <= '0;
					state_q <= ST_MULP;
				end
				ST_DONE: begin
					// The result beat waits here only while the output
					// register still holds an untaken beat.
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// The covariance product lands on the final multiply step.
			if (state_q == ST_MULP && cnt_q == MUL_LAST) begin
				cov_q <= alu_sum[DW-1:0];
			end
		end
	end

	// Output register: loaded as the sequencer leaves its final step.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata <= OUT_W'({sat_q, cov_q, gain_q, est_q});
		end
	end

`ifndef SYNTHESIS
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (gain_q <= GAIN_ONE))
		else $error("gain above one at result");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !den_zero_q) |-> (rem_q < den_q))
		else $error("divide remainder not below divisor");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_DONE))
		else $error("result beat raised outside the final step");

	a_restart_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_tuser == ACT_RESTART) |=>
		(state_q == ST_DONE && gain_q == '0 && !sat_q))
		else $error("restart did not report zero gain and no clipping");
`endif

endmodule
